FILE: rtl/dtp_pkg.sv
// Shared types and constants for the depth-to-point-cloud block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;

  // Fixed field widths
  localparam int FRAME_W    = 13;
  localparam int INV_W      = 32;
  localparam int CTR_W      = 16;
  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // |column*16 - cx| stays below 2^20 for any counter of up to 16 bits
  localparam int MAG_W  = 20;
  localparam int PROD_W = MAG_W + DEPTH_W;            // |d| * depth
  localparam int LO_W   = 16 + INV_W;                 // low 16 bits times 1/f
  localparam int HI_W   = (PROD_W - 16) + INV_W;      // high bits times 1/f
  localparam int SUM_W  = PROD_W + INV_W + 1;
  localparam int RND_SH = 28;                         // Q.36 -> Q.8

  localparam int QUEUE_DEPTH = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = 40'd549755813887;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H     = 3'd5;

  // Reset values
  localparam logic [INV_W-1:0]   RST_INV_FOCAL = 32'd8589934;
  localparam logic [CTR_W-1:0]   RST_PRINCIPAL_X = 16'd5120;
  localparam logic [CTR_W-1:0]   RST_PRINCIPAL_Y = 16'd3840;
  localparam logic [FRAME_W-1:0] RST_FRAME_W = 13'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_H = 13'd480;

  typedef struct packed {
    logic [INV_W-1:0]   inv_focal_x;
    logic [INV_W-1:0]   inv_focal_y;
    logic [CTR_W-1:0]   principal_x;
    logic [CTR_W-1:0]   principal_y;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } dtp_cfg_t;

  // One classified pixel on its way from front to back
  typedef struct packed {
    logic [MAG_W-1:0]   mag_x;
    logic               neg_x;
    logic [MAG_W-1:0]   mag_y;
    logic               neg_y;
    logic [DEPTH_W-1:0] depth;
    logic               frame_end;
  } dtp_item_t;

endpackage

FILE: rtl/depth_to_point_cloud_unit.sv
// Top level of the depth-to-point-cloud block: configuration registers,
// front end, request queue and projection back end. Depends on dtp_pkg,
// dtp_front, dtp_fifo and dtp_back.
//
//   channel   direction  handshake               payload
//   in_*      in         push / full             in_depth
//   out_*     out        empty / pop             out_point_x/y/z, out_frame_end
//   cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per cycle sustained while out_pop stays high; a pushed pixel passes
// through the queue and the three registered back-end stages (depth product,
// split 1/f products, round and clamp) before its result shows up. rst_n
// (synchronous) clears the raster counters, queue and stage valids, and loads
// the default intrinsics and 640x480 frame. Holding pop low stalls the back
// end; the 2-entry queue then fills and full rises. cfg_ready is always high.
`timescale 1ns / 1ps

module depth_to_point_cloud_unit
  import dtp_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [DEPTH_W-1:0]        in_depth,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic [DEPTH_W-1:0]        out_point_z,
  output logic                      out_frame_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  dtp_cfg_t  cfg_r, cfg_nxt;
  dtp_item_t push_item, pop_item;
  logic      q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_FOCAL_X: cfg_nxt.inv_focal_x  = cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y: cfg_nxt.inv_focal_y  = cfg_data[INV_W-1:0];
        REG_PRINCIPAL_X: cfg_nxt.principal_x  = cfg_data[CTR_W-1:0];
        REG_PRINCIPAL_Y: cfg_nxt.principal_y  = cfg_data[CTR_W-1:0];
        REG_FRAME_W:     cfg_nxt.frame_width  = cfg_data[FRAME_W-1:0];
        REG_FRAME_H:     cfg_nxt.frame_height = cfg_data[FRAME_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_focal_x  <= RST_INV_FOCAL;
      cfg_r.inv_focal_y  <= RST_INV_FOCAL;
      cfg_r.principal_x  <= RST_PRINCIPAL_X;
      cfg_r.principal_y  <= RST_PRINCIPAL_Y;
      cfg_r.frame_width  <= RST_FRAME_W;
      cfg_r.frame_height <= RST_FRAME_H;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dtp_front #(
    .MAX_DIM (MAX_DIMENSION)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_depth (in_depth),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  dtp_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (pop_item)
  );

  dtp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .inv_focal_x   (cfg_r.inv_focal_x),
    .inv_focal_y   (cfg_r.inv_focal_y),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: rtl/dtp_front.sv
// Front end: raster counters, frame-end detection and signed offset from
// the principal point for each accepted pixel. Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_front
  import dtp_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIMENSION_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [DEPTH_W-1:0] in_depth,
  input  dtp_cfg_t           cfg,
  input  logic               q_full,
  output logic               q_push,
  output dtp_item_t          q_item
);

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int SZ_BIT = $clog2(MAX_DIM + 1);
  localparam int SZ_W   = (SZ_BIT > FRAME_W) ? SZ_BIT : FRAME_W;
  localparam int OFS_W  = ((CNT_W + 4 > CTR_W) ? CNT_W + 4 : CTR_W) + 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [SZ_W-1:0]  w_raw, h_raw, w_eff, h_eff;
  logic             last_col, last_row;
  logic signed [OFS_W-1:0] d_x, d_y;
  logic [OFS_W-1:0] abs_x, abs_y;

  assign q_push = in_push && !q_full;

  // width/height of zero act as one, anything past the maximum is clamped
  always_comb begin
    w_raw = SZ_W'(cfg.frame_width);
    h_raw = SZ_W'(cfg.frame_height);
    if (w_raw == '0) begin
      w_eff = SZ_W'(1);
    end else if (w_raw > SZ_W'(MAX_DIM)) begin
      w_eff = SZ_W'(MAX_DIM);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = SZ_W'(1);
    end else if (h_raw > SZ_W'(MAX_DIM)) begin
      h_eff = SZ_W'(MAX_DIM);
    end else begin
      h_eff = h_raw;
    end
  end

  // >= so that a frame shrunk mid-way still wraps
  assign last_col = SZ_W'(col_r) >= (w_eff - SZ_W'(1));
  assign last_row = SZ_W'(row_r) >= (h_eff - SZ_W'(1));

  always_comb begin
    d_x   = $signed(OFS_W'({col_r, 4'b0000})) - $signed(OFS_W'(cfg.principal_x));
    d_y   = $signed(OFS_W'({row_r, 4'b0000})) - $signed(OFS_W'(cfg.principal_y));
    abs_x = d_x[OFS_W-1] ? OFS_W'(-d_x) : OFS_W'(d_x);
    abs_y = d_y[OFS_W-1] ? OFS_W'(-d_y) : OFS_W'(d_y);

    q_item.mag_x     = MAG_W'(abs_x[OFS_W-2:0]);
    q_item.neg_x     = d_x[OFS_W-1];
    q_item.mag_y     = MAG_W'(abs_y[OFS_W-2:0]);
    q_item.neg_y     = d_y[OFS_W-1];
    q_item.depth     = in_depth;
    q_item.frame_end = last_col && last_row;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.frame_end |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after frame end");

endmodule

FILE: rtl/dtp_fifo.sv
// Two-entry request queue between front and back ends.
// Depends on dtp_pkg for the item type and queue depth.
`timescale 1ns / 1ps

module dtp_fifo
  import dtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dtp_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output dtp_item_t rd_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dtp_item_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request popped from empty queue");

endmodule

FILE: rtl/dtp_back.sv
// Back end: three-stage projection pipeline (depth product, split
// reciprocal products, round/saturate/sign). Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_back
  import dtp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  dtp_item_t                 q_item,
  output logic                      q_pop,
  input  logic [INV_W-1:0]          inv_focal_x,
  input  logic [INV_W-1:0]          inv_focal_y,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic [DEPTH_W-1:0]        out_point_z,
  output logic                      out_frame_end
);

  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (RND_SH - 1);

  // (hi*2^16 + lo + half) >> 28, clamp, then apply sign
  function automatic logic [COORD_W-1:0] finish(input logic [HI_W-1:0] hi,
                                                input logic [LO_W-1:0] lo,
                                                input logic            neg);
    logic [SUM_W-1:0]          sum;
    logic [SUM_W-RND_SH-1:0]   q;
    logic [COORD_W-1:0]        mag;
    sum = SUM_W'({hi, 16'h0000}) + SUM_W'(lo) + ROUND_BIAS;
    q   = sum[SUM_W-1:RND_SH];
    mag = (q > (SUM_W-RND_SH)'(COORD_MAX)) ? COORD_MAX : q[COORD_W-1:0];
    return neg ? -mag : mag;
  endfunction

  logic adv1, adv2, adv3;

  logic               s1_v_r;
  logic [PROD_W-1:0]  s1_px_r, s1_py_r;
  logic               s1_neg_x_r, s1_neg_y_r, s1_fe_r;
  logic [DEPTH_W-1:0] s1_depth_r;

  logic               s2_v_r;
  logic [HI_W-1:0]    s2_hx_r, s2_hy_r;
  logic [LO_W-1:0]    s2_lx_r, s2_ly_r;
  logic               s2_neg_x_r, s2_neg_y_r, s2_fe_r;
  logic [DEPTH_W-1:0] s2_depth_r;

  logic                      s3_v_r;
  logic signed [COORD_W-1:0] s3_x_r, s3_y_r;
  logic [DEPTH_W-1:0]        s3_z_r;
  logic                      s3_fe_r;

  assign adv3  = !s3_v_r || out_pop;
  assign adv2  = !s2_v_r || adv3;
  assign adv1  = !s1_v_r || adv2;
  assign q_pop = !q_empty && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= !q_empty;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_px_r    <= PROD_W'(q_item.mag_x) * PROD_W'(q_item.depth);
      s1_py_r    <= PROD_W'(q_item.mag_y) * PROD_W'(q_item.depth);
      s1_neg_x_r <= q_item.neg_x;
      s1_neg_y_r <= q_item.neg_y;
      s1_depth_r <= q_item.depth;
      s1_fe_r    <= q_item.frame_end;
    end
    if (adv2) begin
      s2_hx_r    <= HI_W'(s1_px_r[PROD_W-1:16]) * HI_W'(inv_focal_x);
      s2_lx_r    <= LO_W'(s1_px_r[15:0]) * LO_W'(inv_focal_x);
      s2_hy_r    <= HI_W'(s1_py_r[PROD_W-1:16]) * HI_W'(inv_focal_y);
      s2_ly_r    <= LO_W'(s1_py_r[15:0]) * LO_W'(inv_focal_y);
      s2_neg_x_r <= s1_neg_x_r;
      s2_neg_y_r <= s1_neg_y_r;
      s2_depth_r <= s1_depth_r;
      s2_fe_r    <= s1_fe_r;
    end
    if (adv3) begin
      s3_x_r  <= $signed(finish(s2_hx_r, s2_lx_r, s2_neg_x_r));
      s3_y_r  <= $signed(finish(s2_hy_r, s2_ly_r, s2_neg_y_r));
      s3_z_r  <= s2_depth_r;
      s3_fe_r <= s2_fe_r;
    end
  end

  assign out_empty     = !s3_v_r;
  assign out_point_x   = s3_x_r;
  assign out_point_y   = s3_y_r;
  assign out_point_z   = s3_z_r;
  assign out_frame_end = s3_fe_r;

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && adv2 |=> s2_v_r)
    else $error("request lost between product stages");

  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_depth_r == '0 && adv3 |=> s3_x_r == '0 && s3_y_r == '0)
    else $error("zero depth gave a nonzero coordinate");

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for depth_to_point_cloud_unit: drives depth pixels and register writes,
// predicts every 3D point and checks each one. Depends on dtp_pkg and the rtl/ sources.
`timescale 1ns / 1ps

module tb_top;
  import dtp_pkg::*;

  localparam int NUM_REGS = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_PIXELS = 1000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
    logic                      frame_end;
  } point_t;

  class point_scoreboard;
    logic [INV_W-1:0]   inv_fx, inv_fy;
    logic [CTR_W-1:0]   centre_x, centre_y;
    logic [FRAME_W-1:0] cols_cfg, rows_cfg;
    logic [11:0]        col, row;
    point_t             expected_points[$];
    int                 errors, checked, frame_ends;

    function new();
      inv_fx = RST_INV_FOCAL;
      inv_fy = RST_INV_FOCAL;
      centre_x = RST_PRINCIPAL_X;
      centre_y = RST_PRINCIPAL_Y;
      cols_cfg = RST_FRAME_W;
      rows_cfg = RST_FRAME_H;
      col = '0;
      row = '0;
      errors = 0;
      checked = 0;
      frame_ends = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INV_FOCAL_X: inv_fx = data;
        REG_INV_FOCAL_Y: inv_fy = data;
        REG_PRINCIPAL_X: centre_x = data[CTR_W-1:0];
        REG_PRINCIPAL_Y: centre_y = data[CTR_W-1:0];
        REG_FRAME_W:     cols_cfg = data[FRAME_W-1:0];
        REG_FRAME_H:     rows_cfg = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    static function logic [FRAME_W-1:0] clamp_size(logic [FRAME_W-1:0] v);
      if (v == '0) return FRAME_W'(1);
      if (v > FRAME_W'(MAX_DIMENSION_DEF)) return FRAME_W'(MAX_DIMENSION_DEF);
      return v;
    endfunction

    // (idx*16 - centre) * depth * inv in Q.36, rounded half away from zero to Q.8
    static function logic signed [COORD_W-1:0] back_project(logic [11:0] idx,
        logic [CTR_W-1:0] centre, logic [DEPTH_W-1:0] depth, logic [INV_W-1:0] inv);
      logic signed [20:0] offset;
      logic               neg;
      logic [19:0]        mag;
      logic [71:0]        prod;
      logic [71:0]        scaled;
      offset = $signed({5'd0, idx, 4'd0}) - $signed({5'd0, centre});
      neg = offset[20];
      if (neg) offset = -offset;
      mag = offset[19:0];
      prod = mag * depth * inv;
      scaled = (prod + 72'h800_0000) >> 28;
      if (scaled > COORD_MAX) scaled = COORD_MAX;
      return neg ? -$signed(scaled[COORD_W-1:0]) : $signed(scaled[COORD_W-1:0]);
    endfunction

    function void note_depth(logic [DEPTH_W-1:0] depth);
      logic [FRAME_W-1:0] w, h;
      logic               last_col, last_row;
      point_t             p;
      w = clamp_size(cols_cfg);
      h = clamp_size(rows_cfg);
      // a counter past a shrunk frame edge counts as sitting on it
      last_col = (col >= w - 1'b1);
      last_row = (row >= h - 1'b1);
      p.x = back_project(col, centre_x, depth, inv_fx);
      p.y = back_project(row, centre_y, depth, inv_fy);
      p.z = depth;
      p.frame_end = last_col && last_row;
      expected_points.push_back(p);
      if (last_col) begin
        col = '0;
        row = last_row ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= 20)
        $display("MISMATCH %s at point %0d: got %0d, want %0d (t=%0t)",
                 what, checked, got, want, $time);
    endtask

    task check_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                     logic [DEPTH_W-1:0] z, logic fe);
      point_t want;
      checked++;
      if (expected_points.size() == 0) begin
        report("point with no pixel pending", x, 0);
        return;
      end
      want = expected_points.pop_front();
      if (x !== want.x) report("point_x", x, want.x);
      if (y !== want.y) report("point_y", y, want.y);
      if (z !== want.z) report("point_z", z, want.z);
      if (fe !== want.frame_end) report("frame_end", fe, want.frame_end);
      if (fe === 1'b1) frame_ends++;
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic [DEPTH_W-1:0]        in_depth = '0;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic [DEPTH_W-1:0]        out_point_z;
  logic                      out_frame_end;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  point_scoreboard      sb;
  logic [CFG_DATA_W-1:0] next_regs [NUM_REGS];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int full_stalls = 0;
  int reg_writes = 0;
  int phases = 0;

  depth_to_point_cloud_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_depth      (in_depth),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout: block stopped making progress");
    $display("Some tests failed");
    $finish;
  end

  // result side: check, then decide next cycle's pop (long hold-off on request)
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_point(out_point_x, out_point_y, out_point_z, out_frame_end);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_depth(input logic [DEPTH_W-1:0] depth);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push  <= 1'b1;
    in_depth <= depth;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    sb.note_depth(depth);
    pixels_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic apply_regs(input logic [NUM_REGS-1:0] which);
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = CFG_IDX_W'(i);
      if (which[i]) cfg_write(idx, next_regs[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // every pixel yields a point, so an empty queue means the block is idle
  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [NUM_REGS-1:0] which;
    logic [DEPTH_W-1:0]  depth;
    int                  count;
    int                  random_end;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset intrinsics, first row, negative x
    send_depth(16'd0);
    send_depth(16'hFFFF);
    send_depth(16'd1);
    send_depth(16'h8000);
    wait_drained();

    // width 0 acts as 1 and the column counter sits past the new edge
    next_regs[REG_INV_FOCAL_X] = 32'hFFFF_FFFF;
    next_regs[REG_INV_FOCAL_Y] = 32'd1;
    next_regs[REG_PRINCIPAL_X] = 32'd0;
    next_regs[REG_PRINCIPAL_Y] = 32'h0000_FFFF;
    next_regs[REG_FRAME_W]     = 32'd0;
    next_regs[REG_FRAME_H]     = 32'd3;
    apply_regs('1);
    send_depth(16'hFFFF);
    send_depth(16'hFFFF);
    send_depth(16'hAAAA);
    send_depth(16'h5555);
    wait_drained();

    // zero reciprocal, width above the maximum, writes to unmapped indexes
    next_regs[REG_INV_FOCAL_X] = 32'd0;
    next_regs[REG_INV_FOCAL_Y] = 32'hFFFF_FFFF;
    next_regs[REG_PRINCIPAL_X] = 32'h0000_FFFF;
    next_regs[REG_PRINCIPAL_Y] = 32'd0;
    next_regs[REG_FRAME_W]     = 32'h0000_1FFF;
    next_regs[REG_FRAME_H]     = 32'd1;
    cfg_write(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED_HI, 32'h1234_5678);
    apply_regs('1);
    send_depth(16'hFFFF);
    send_depth(16'h5555);
    send_depth(16'hAAAA);
    send_depth(16'hFFFF);
    send_depth(16'd0);
    wait_drained();

    // height 0 acts as 1
    next_regs[REG_FRAME_W] = 32'd2;
    next_regs[REG_FRAME_H] = 32'd0;
    apply_regs(NUM_REGS'((1 << REG_FRAME_W) | (1 << REG_FRAME_H)));
    repeat (5) send_depth(DEPTH_W'($urandom));
    wait_drained();

    // largest legal frame
    next_regs[REG_INV_FOCAL_X] = 32'd8589934;
    next_regs[REG_PRINCIPAL_X] = 32'd5120;
    next_regs[REG_FRAME_W]     = 32'd4096;
    next_regs[REG_FRAME_H]     = 32'd4096;
    apply_regs(NUM_REGS'((1 << REG_INV_FOCAL_X) | (1 << REG_PRINCIPAL_X) |
                         (1 << REG_FRAME_W) | (1 << REG_FRAME_H)));
    send_depth(16'hFFFF);
    send_depth(16'd0);
    send_depth(16'h7FFF);

    random_end = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_end) begin
      wait_drained();
      case (phases % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase

      for (int i = REG_INV_FOCAL_X; i <= REG_INV_FOCAL_Y; i++)
        case ($urandom_range(5))
          0: next_regs[i] = 32'd0;
          1: next_regs[i] = 32'hFFFF_FFFF;
          2: next_regs[i] = 32'd1;
          3: next_regs[i] = $urandom;
          default: next_regs[i] = 32'hFFFF_FFFF / $urandom_range(100, 2000);
        endcase
      for (int i = REG_PRINCIPAL_X; i <= REG_PRINCIPAL_Y; i++)
        case ($urandom_range(4))
          0: next_regs[i] = 32'd0;
          1: next_regs[i] = 32'h0000_FFFF;
          2: next_regs[i] = $urandom_range(0, 320);
          default: next_regs[i] = $urandom;
        endcase
      // mostly tiny frames so that frame ends come often
      for (int i = REG_FRAME_W; i <= REG_FRAME_H; i++)
        case ($urandom_range(11))
          0: next_regs[i] = 32'd0;
          1: next_regs[i] = $urandom_range(4096, 8191);
          2: next_regs[i] = $urandom;
          3: next_regs[i] = $urandom_range(17, 200);
          default: next_regs[i] = $urandom_range(1, 10);
        endcase
      which = (phases == 0) ? '1 : NUM_REGS'($urandom_range(1, (1 << NUM_REGS) - 1));
      if ($urandom_range(9) == 0)
        cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
      apply_regs(which);

      // stall the result side for a long stretch so the input backs up
      if (phases == 5 || phases == 22) begin
        idle_pct = 0;
        hold_request = HOLD_CYCLES;
      end

      count = $urandom_range(8, 60);
      repeat (count) begin
        case ($urandom_range(7))
          0: depth = '0;
          1: depth = '1;
          2: depth = DEPTH_W'($urandom_range(0, 255));
          default: depth = DEPTH_W'($urandom);
        endcase
        send_depth(depth);
      end
      phases++;
    end
    wait_drained();

    $display("Run covered %0d depth pixels over %0d random setting phases, %0d register writes.",
             pixels_sent, phases, reg_writes);
    $display("%0d points checked, %0d frame ends, input held off by full for %0d cycles.",
             sb.checked, sb.frame_ends, full_stalls);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/dtp_pkg.sv
rtl/dtp_front.sv
rtl/dtp_fifo.sv
rtl/dtp_back.sv
rtl/depth_to_point_cloud_unit.sv
verif/tb_top.sv
